[rtl/vafc_pkg.sv]
`timescale 1ns / 1ps

package vafc_pkg;

   // Datapath width of the rotating vector and of the angle accumulator.
   localparam int XY_WIDTH  = 64;
   localparam int ACC_WIDTH = 32;
   localparam int TABLE_LEN = 32;

   // Fixed angles as fractions of a full turn, 2^32 = one turn.
   localparam logic [ACC_WIDTH-1:0] TURN_ZERO           = 32'h0000_0000;
   localparam logic [ACC_WIDTH-1:0] TURN_QUARTER        = 32'h4000_0000;
   localparam logic [ACC_WIDTH-1:0] TURN_HALF           = 32'h8000_0000;
   localparam logic [ACC_WIDTH-1:0] TURN_THREE_QUARTERS = 32'hC000_0000;

   // atan(2^-i) / (2*pi) * 2^32
   localparam logic [ACC_WIDTH-1:0] ATAN_TURNS [0:TABLE_LEN-1] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
   };

   // Contents of one pipeline slot. A bypassed slot already holds its final
   // angle and passes the rotation cells untouched.
   typedef struct packed {
      logic                        valid;
      logic                        bypass;
      logic signed [XY_WIDTH-1:0]  x;
      logic signed [XY_WIDTH-1:0]  y;
      logic [ACC_WIDTH-1:0]        acc;
   } stage_type;

endpackage

[rtl/vafc_entry.sv]
`timescale 1ns / 1ps

module vafc_entry import vafc_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [COORD_WIDTH-1:0] x_coord,
   input  logic [COORD_WIDTH-1:0] y_coord,
   output stage_type              stage_out
);

   localparam int FRAC_BITS = 61 - COORD_WIDTH;

   stage_type                  stage_ff;
   stage_type                  stage_in;
   logic signed [XY_WIDTH-1:0] x_ext;
   logic signed [XY_WIDTH-1:0] y_ext;
   logic signed [XY_WIDTH-1:0] x_fold;
   logic signed [XY_WIDTH-1:0] y_fold;
   logic                       x_zero;
   logic                       x_neg;
   logic                       y_pos;

   always_comb begin
      x_ext  = {{(XY_WIDTH-COORD_WIDTH){x_coord[COORD_WIDTH-1]}}, x_coord};
      y_ext  = {{(XY_WIDTH-COORD_WIDTH){y_coord[COORD_WIDTH-1]}}, y_coord};
      x_zero = (x_coord == '0);
      x_neg  = x_coord[COORD_WIDTH-1];
      y_pos  = !y_coord[COORD_WIDTH-1] && (y_coord != '0);

      // A vector in the left half plane is turned by a half turn first.
      x_fold = x_neg ? -x_ext : x_ext;
      y_fold = x_neg ? -y_ext : y_ext;

      stage_in.valid = in_valid;
      stage_in.x     = x_fold <<< FRAC_BITS;
      stage_in.y     = y_fold <<< FRAC_BITS;
      if (x_zero) begin
         stage_in.bypass = 1'b1;
         stage_in.acc    = y_pos ? TURN_QUARTER : TURN_THREE_QUARTERS;
      end else begin
         stage_in.bypass = (y_coord == '0);
         stage_in.acc    = x_neg ? TURN_HALF : TURN_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

[rtl/vafc_cell.sv]
`timescale 1ns / 1ps

module vafc_cell import vafc_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type prev_stage,
   output stage_type stage_out
);

   stage_type                  stage_ff;
   stage_type                  stage_in;
   logic signed [XY_WIDTH-1:0] x_shift;
   logic signed [XY_WIDTH-1:0] y_shift;
   logic                       y_pos;

   always_comb begin
      x_shift  = prev_stage.x >>> STAGE;
      y_shift  = prev_stage.y >>> STAGE;
      y_pos    = !prev_stage.y[XY_WIDTH-1] && (prev_stage.y != '0);
      stage_in = prev_stage;
      if (!prev_stage.bypass) begin
         // Rotate towards the x axis and book the angle turned through.
         if (y_pos) begin
            stage_in.x   = prev_stage.x + y_shift;
            stage_in.y   = prev_stage.y - x_shift;
            stage_in.acc = prev_stage.acc + ATAN_TURNS[STAGE];
         end else begin
            stage_in.x   = prev_stage.x - y_shift;
            stage_in.y   = prev_stage.y + x_shift;
            stage_in.acc = prev_stage.acc - ATAN_TURNS[STAGE];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

[rtl/vector_angle_full_turn_core.sv]
// Every accepted request passes the entry register, the chain of rotation cells and
// the output register in order; one transaction per cycle enters while no response stalls.
// The whole chain halts together only while a response waits on rsp_tready.
// Reset is synchronous and active high; it clears every valid flag, while the
// coordinate and angle registers keep whatever they held.
`timescale 1ns / 1ps

module vector_angle_full_turn_core import vafc_pkg::*; #(
   parameter int COORD_WIDTH     = 16,
   parameter int ANGLE_WIDTH     = 16,
   parameter int ROTATION_STAGES = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // req_tdata fields from bit 0 up: x_coord, y_coord, zero padding.
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // rsp_tdata fields from bit 0 up: turn_angle, zero padding.
   output logic [((ANGLE_WIDTH+7)/8)*8-1:0]       rsp_tdata
);

   localparam int RSP_WIDTH  = ((ANGLE_WIDTH + 7) / 8) * 8;
   localparam int DROP_BITS  = ACC_WIDTH - ANGLE_WIDTH;
   // Half of the lowest kept bit, for round half up; zero when nothing drops.
   localparam logic [ACC_WIDTH-1:0] ROUND_HALF = (32'd1 << DROP_BITS) >> 1;

   // The chain moves as one whenever the output register is free or is being
   // emptied in this cycle; while it does, a new transaction can enter every cycle.
   logic                    advance;
   stage_type               chain [0:ROTATION_STAGES];
   logic [ACC_WIDTH-1:0]    rounded;
   logic                    rsp_tvalid_ff;
   logic                    rsp_tvalid_in;
   logic [RSP_WIDTH-1:0]    rsp_tdata_ff;
   logic [RSP_WIDTH-1:0]    rsp_tdata_in;

   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;

   // Input stage: quadrant folding, fixed-point scaling and the axis cases.
   vafc_entry #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_entry (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .x_coord   (req_tdata[COORD_WIDTH-1:0]),
      .y_coord   (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .stage_out (chain[0])
   );

   // One micro-rotation per cell; cell k shifts by k and uses atan(2^-k).
   for (genvar k = 0; k < ROTATION_STAGES; k++) begin : g_cell
      vafc_cell #(
         .STAGE (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .prev_stage (chain[k]),
         .stage_out  (chain[k+1])
      );
   end

   // The 32-bit turn fraction is rounded half up and wraps, so an angle just
   // short of a full turn can come out as zero.
   always_comb begin
      rounded       = chain[ROTATION_STAGES].acc + ROUND_HALF;
      rsp_tvalid_in = chain[ROTATION_STAGES].valid;
      rsp_tdata_in  = '0;
      rsp_tdata_in[ANGLE_WIDTH-1:0] = rounded[ACC_WIDTH-1 -: ANGLE_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

[rtl/vafc_checker.sv]
`timescale 1ns / 1ps

module vafc_checker #(
   parameter int COORD_WIDTH = 16,
   parameter int ANGLE_WIDTH = 16
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [((ANGLE_WIDTH+7)/8)*8-1:0]   rsp_tdata
);

   // A response that is not taken stays, unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed or vanished");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response present right after reset");

   // With the output register empty nothing may hold back a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused while output is empty");

   // A blocked response freezes the whole chain, the input included.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while the chain is stalled");

   // An accepted request carries fully known coordinates.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !$isunknown(req_tdata))
      else $error("request accepted with unknown coordinates");

endmodule

bind vector_angle_full_turn_core vafc_checker #(
   .COORD_WIDTH (COORD_WIDTH),
   .ANGLE_WIDTH (ANGLE_WIDTH)
) u_vafc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
